[src/block_bitmap_allocator_macros.svh]
// Assertion shorthands for the bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bba_pkg.sv]
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 64;
  localparam int unsigned BLOCK_W        = 12;
  localparam int unsigned COUNT_W        = 13;
  localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FREE  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

[src/bba_if.sv]
`default_nettype none

interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [bba_pkg::BLOCK_W-1:0] block_number;

  modport source (output valid, output operation, output block_number, input ready);
  modport sink   (input valid, input operation, input block_number, output ready);
endinterface

interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::BLOCK_W-1:0] allocated_block;
  logic [1:0]                  status;

  modport source (output valid, output allocated_block, output status, input ready);
  modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

`default_nettype wire

[src/bba_map_ram.sv]
`default_nettype none

module bba_map_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/bba_scan_unit.sv]
`default_nettype none

module bba_scan_unit #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned LIM_W     = 13
) (
  input  wire logic [WORD_BITS-1:0] word_i,
  input  wire logic [LIM_W-1:0]     base_i,
  input  wire logic [LIM_W-1:0]     limit_i,
  output logic                      found_o,
  output logic [IDX_W-1:0]          idx_o,
  output logic [WORD_BITS-1:0]      mask_o
);

  logic [LIM_W-1:0]     rem;
  logic [WORD_BITS-1:0] avail;

  assign rem = (limit_i > base_i) ? (limit_i - base_i) : '0;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = !word_i[i] && (LIM_W'(i) < rem);
    end
  end

  // isolate the lowest free bit
  assign mask_o  = avail & (~avail + WORD_BITS'(1));
  assign found_o = |avail;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      idx_o = idx_o | (mask_o[i] ? IDX_W'(i) : '0);
    end
  end

endmodule

`default_nettype wire

[src/block_bitmap_allocator.sv]
// Channel   Dir  Payload                           Word moves when
// req_i     in   operation, block_number           req_i.valid && req_i.ready
// rsp_o     out  allocated_block, status           rsp_o.valid && rsp_o.ready
// cfg       in   cfg_wdata_i (block_count)         cfg_we_i
//
// Allocate: the request is accepted, then bitmap words are scanned one by one, at most
//   MAX_BLOCKS / WORD_BITS words (64 at defaults); the single map read port sets the pace.
// Free: one map read, then the write back unless the free is out of range or a double free.
// Reset: a clearing pass writes every map word (MAX_BLOCKS / WORD_BITS words,
//   64 at defaults), with req_i.ready low.
// A new request is taken while a result waits in the output register; the
//   sequencer then holds before its result until rsp_o drains.
`default_nettype none
`include "block_bitmap_allocator_macros.svh"

module block_bitmap_allocator #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bba_pkg::COUNT_W-1:0] cfg_wdata_i,
  bba_req_if.sink                          req_i,
  bba_rsp_if.source                        rsp_o
);

  import bba_pkg::*;

  localparam int unsigned MAP_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned IDX_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LIM_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [AW-1:0]          w_q, w_d;
  logic [LIM_W-1:0]       base_q, base_d;
  logic [BLOCK_W-1:0]     blk_q, blk_d;
  logic [COUNT_W-1:0]     cnt_q;
  logic                   out_valid_q, out_valid_d;
  logic [BLOCK_W-1:0]     out_blk_q, out_blk_d;
  status_e                out_st_q, out_st_d;

  logic [LIM_W-1:0]       cnt_ext, limit, blk_ext;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;
  logic [WORD_BITS-1:0]   wr_data, rd_data, bit_mask;
  logic                   scan_found, scan_done, can_out, finish;
  logic [IDX_W-1:0]       scan_idx, bit_sel;
  logic [WORD_BITS-1:0]   scan_mask;

  assign cnt_ext  = LIM_W'(cnt_q);
  assign limit    = (cnt_ext > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : cnt_ext;
  assign blk_ext  = LIM_W'(blk_q);
  assign bit_sel  = IDX_W'(blk_ext % WORD_BITS);
  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
  assign can_out  = !out_valid_q || rsp_o.ready;

  assign scan_done = scan_found || (w_q == AW'(MAP_WORDS - 1)) ||
                     ((base_q + LIM_W'(WORD_BITS)) >= limit);

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bba_scan_unit #(
    .WORD_BITS (WORD_BITS),
    .IDX_W     (IDX_W),
    .LIM_W     (LIM_W)
  ) u_scan (
    .word_i  (rd_data),
    .base_i  (base_q),
    .limit_i (limit),
    .found_o (scan_found),
    .idx_o   (scan_idx),
    .mask_o  (scan_mask)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    w_d         = w_q;
    base_d      = base_q;
    blk_d       = blk_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_blk_d   = out_blk_q;
    out_st_d    = out_st_q;
    rd_addr     = w_q;
    wr_en       = 1'b0;
    wr_addr     = w_q;
    wr_data     = rd_data;
    req_i.ready = 1'b0;
    finish      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          blk_d = req_i.block_number;
          if (op_e'(req_i.operation) == OP_FREE) begin
            w_d     = AW'(LIM_W'(req_i.block_number) / WORD_BITS);
            rd_addr = w_d;
            state_d = S_FREE;
          end else begin
            w_d     = '0;
            base_d  = '0;
            rd_addr = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          w_d     = w_q + AW'(1);
          base_d  = base_q + LIM_W'(WORD_BITS);
          rd_addr = w_d;
        end else if (can_out) begin
          finish      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (scan_found) begin
            wr_en     = 1'b1;
            wr_data   = rd_data | scan_mask;
            out_blk_d = BLOCK_W'(base_q + LIM_W'(scan_idx));
            out_st_d  = ST_OK;
          end else begin
            out_blk_d = '0;
            out_st_d  = ST_EMPTY;
          end
        end
      end
      S_FREE: begin
        if (can_out) begin
          finish      = 1'b1;
          out_valid_d = 1'b1;
          out_blk_d   = '0;
          state_d     = S_IDLE;
          if (blk_ext >= limit) begin
            out_st_d = ST_RANGE;
          end else if ((rd_data & bit_mask) == '0) begin
            out_st_d = ST_DOUBLE_FREE;
          end else begin
            wr_en    = 1'b1;
            wr_data  = rd_data & ~bit_mask;
            out_st_d = ST_OK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    base_q    <= base_d;
    blk_q     <= blk_d;
    out_blk_q <= out_blk_d;
    out_st_q  <= out_st_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.allocated_block = out_blk_q;
  assign rsp_o.status          = out_st_q;

  `BBA_ASSERT_IMP(a_no_accept_in_clear, clk_i, rst_ni, state_q == S_CLEAR, !req_i.ready, "request taken during map clear")
  `BBA_ASSERT_IMP(a_finish_has_room, clk_i, rst_ni, finish, !out_valid_q || rsp_o.ready, "result overwrites pending word")
  `BBA_ASSERT_IMP(a_grant_below_limit, clk_i, rst_ni, finish && state_q == S_SCAN && scan_found, (base_q + LIM_W'(scan_idx)) < limit, "grant at or above block count")
  `BBA_ASSERT_NXT(a_scan_in_bounds, clk_i, rst_ni, state_q == S_SCAN && !scan_done, state_q == S_SCAN && base_q < limit, "scan ran past block count")

endmodule

`default_nettype wire
